FILE: sv/cdf_pkg.sv
package cdf_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int CH_FIELD_W  = 10;
  localparam int BS_FIELD_W  = 2;
  localparam int TAP_FIELD_W = 3;
  localparam int KTAPS_W     = 4;

  // defaults for the top-level parameters
  localparam int CHANNELS_DEF    = 1024;
  localparam int MAX_TAPS_DEF    = 8;
  localparam int BATCH_SLOTS_DEF = 4;

  localparam logic [KTAPS_W-1:0] KTAPS_RESET = 4'd4;

  // q10.22 sum back to q8.8
  localparam int FRAC_SHIFT = 14;
  localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
  localparam int SAT_HI     = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAT_LO     = -(1 << (SAMPLE_BITS - 1));

  // request kinds
  localparam logic REQ_COEF   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic                           req_type;
    logic [BS_FIELD_W-1:0]          batch_slot;
    logic [CH_FIELD_W-1:0]          channel_index;
    logic [TAP_FIELD_W-1:0]         tap_index;
    logic signed [SAMPLE_BITS-1:0]  data_value;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0]  filtered_value;
    logic [CH_FIELD_W-1:0]          out_channel;
    logic [BS_FIELD_W-1:0]          out_batch;
    logic                           saturated;
  } rsp_t;

endpackage

FILE: sv/cdf_ram.sv
module cdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read: data out the cycle after rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/causal_depthwise_fir.sv
// sample path: memory reads on the transfer, S_READ (history read-modify-write, products),
//   S_SUM, then S_OUT, which waits while an older result is held downstream; a coefficient
//   write is a weight read-modify-write in S_READ; in_stall is high outside S_IDLE, so requests never overlap
// reset: synchronous, active low; afterwards the history memory is swept to zero, one line
//   per cycle over all HIST_DEPTH lines (4096 with the defaults), with in_stall high; tap
//   weights are undefined until written
module causal_depthwise_fir #(
  parameter int CHANNELS    = cdf_pkg::CHANNELS_DEF,
  parameter int MAX_TAPS    = cdf_pkg::MAX_TAPS_DEF,
  parameter int BATCH_SLOTS = cdf_pkg::BATCH_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cdf_pkg::req_t                in_req,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cdf_pkg::rsp_t                out_rsp,
  input  logic                         cfg_wr_en,
  input  logic [cdf_pkg::KTAPS_W-1:0]  cfg_wr_data
);

  import cdf_pkg::*;

  // address layout: one history line per (slot, channel), all taps in one word
  localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_AW    = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1;
  localparam int HIST_AW    = CH_AW + SLOT_AW;
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam int LINE_W     = MAX_TAPS * SAMPLE_BITS;
  localparam int WLINE_W    = MAX_TAPS * WEIGHT_BITS;
  localparam int TAP_AW     = $clog2(MAX_TAPS);
  localparam int NT_W       = $clog2(MAX_TAPS + 1);
  localparam int PROD_W     = SAMPLE_BITS + WEIGHT_BITS;
  localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS) + 1;

  localparam logic signed [ACC_W-1:0] ACC_HI   = ACC_W'(SAT_HI);
  localparam logic signed [ACC_W-1:0] ACC_LO   = ACC_W'(SAT_LO);
  localparam logic signed [ACC_W-1:0] ACC_BIAS = ACC_W'(ROUND_BIAS);

  typedef enum logic [2:0] {
    S_CLEAR,   // zero sweep over the history memory
    S_IDLE,    // waiting for a transfer, memory reads issued on it
    S_READ,    // line data back: write back, form products
    S_SUM,     // add the products
    S_OUT      // round, saturate, load output register
  } state_t;

  state_t state_r;

  req_t                         req_r;
  logic [KTAPS_W-1:0]           kernel_taps_r;
  logic [HIST_AW-1:0]           clr_cnt_r;
  logic signed [PROD_W-1:0]     prod_r [MAX_TAPS];
  logic signed [ACC_W-1:0]      acc_r;
  logic                         out_valid_r;
  rsp_t                         out_rsp_r;

  logic                         in_xfer;
  logic                         out_xfer;
  logic                         ch_ok;
  logic                         slot_ok;
  logic                         tap_ok;
  logic                         keep;
  logic [31:0]                  in_ch_ext;
  logic [31:0]                  in_slot_ext;
  logic [31:0]                  req_ch_ext;
  logic [31:0]                  req_slot_ext;
  logic [CH_AW-1:0]             in_ch_addr;
  logic [SLOT_AW-1:0]           in_slot_addr;
  logic [HIST_AW-1:0]           req_hist_addr;

  logic                         hist_we;
  logic [HIST_AW-1:0]           hist_waddr;
  logic [LINE_W-1:0]            hist_wdata;
  logic [LINE_W-1:0]            hist_rdata;
  logic [LINE_W-1:0]            new_line;
  logic                         wt_we;
  logic [WLINE_W-1:0]           wt_wdata;
  logic [WLINE_W-1:0]           wt_rdata;

  logic [NT_W-1:0]              ntaps;
  logic signed [PROD_W-1:0]     prod_nxt [MAX_TAPS];
  logic signed [ACC_W-1:0]      acc_nxt;
  logic signed [ACC_W-1:0]      rnd;
  logic signed [ACC_W-1:0]      q;
  rsp_t                         rsp_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // ---------------------------------------------------------------
  // request decode: out-of-range items are dropped without a result
  // ---------------------------------------------------------------
  assign in_ch_ext    = 32'(in_req.channel_index);
  assign in_slot_ext  = 32'(in_req.batch_slot);
  assign in_ch_addr   = in_ch_ext[CH_AW-1:0];
  assign in_slot_addr = in_slot_ext[SLOT_AW-1:0];
  assign ch_ok        = in_ch_ext < 32'(CHANNELS);
  assign slot_ok      = in_slot_ext < 32'(BATCH_SLOTS);
  assign tap_ok       = 32'(in_req.tap_index) < 32'(MAX_TAPS);
  assign keep         = ch_ok && ((in_req.req_type == REQ_COEF) ? tap_ok : slot_ok);

  assign req_ch_ext    = 32'(req_r.channel_index);
  assign req_slot_ext  = 32'(req_r.batch_slot);
  assign req_hist_addr = {req_slot_ext[SLOT_AW-1:0], req_ch_ext[CH_AW-1:0]};

  // ---------------------------------------------------------------
  // memories: history lines and weight lines, both read on the transfer; a sample writes its
  // history line back and a coefficient its weight line in the cycle after, so accesses never overlap
  // ---------------------------------------------------------------
  cdf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_we),
    .wr_addr (hist_waddr),
    .wr_data (hist_wdata),
    .rd_en   (in_xfer),
    .rd_addr ({in_slot_addr, in_ch_addr}),
    .rd_data (hist_rdata)
  );

  cdf_ram #(
    .WIDTH (WLINE_W),
    .DEPTH (1 << CH_AW)
  ) u_wt_ram (
    .clk     (clk),
    .wr_en   (wt_we),
    .wr_addr (req_ch_ext[CH_AW-1:0]),
    .wr_data (wt_wdata),
    .rd_en   (in_xfer),
    .rd_addr (in_ch_addr),
    .rd_data (wt_rdata)
  );

  // history shifts toward tap 0, newest sample goes in the top tap
  assign new_line = {req_r.data_value, hist_rdata[LINE_W-1:SAMPLE_BITS]};

  assign hist_we    = (state_r == S_CLEAR) ||
                      ((state_r == S_READ) && (req_r.req_type == REQ_SAMPLE));
  assign hist_waddr = (state_r == S_CLEAR) ? clr_cnt_r : req_hist_addr;
  assign hist_wdata = (state_r == S_CLEAR) ? '0 : new_line;

  assign wt_we = (state_r == S_READ) && (req_r.req_type == REQ_COEF);

  // weight write merges one tap into the line that was just read
  always_comb begin
    wt_wdata = wt_rdata;
    for (int k = 0; k < MAX_TAPS; k++) begin
      if (32'(req_r.tap_index) == 32'(k)) begin
        wt_wdata[k*WEIGHT_BITS +: WEIGHT_BITS] = req_r.data_value;
      end
    end
  end

  // taps in use: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (kernel_taps_r == '0) begin
      ntaps = NT_W'(1);
    end else if (32'(kernel_taps_r) > 32'(MAX_TAPS)) begin
      ntaps = NT_W'(MAX_TAPS);
    end else begin
      ntaps = NT_W'(kernel_taps_r);
    end
  end

  // ---------------------------------------------------------------
  // products: history tap j meets weight j + ntaps - MAX_TAPS, so the
  // last weight in use lines up with the newest sample
  // ---------------------------------------------------------------
  always_comb begin
    logic [31:0]                   widx;
    logic signed [SAMPLE_BITS-1:0] hs;
    logic signed [WEIGHT_BITS-1:0] ws;
    for (int j = 0; j < MAX_TAPS; j++) begin
      widx = 32'(j) + 32'(ntaps) - 32'(MAX_TAPS);
      hs   = new_line[j*SAMPLE_BITS +: SAMPLE_BITS];
      ws   = wt_rdata[widx[TAP_AW-1:0]*WEIGHT_BITS +: WEIGHT_BITS];
      if (32'(j) + 32'(ntaps) >= 32'(MAX_TAPS)) begin
        prod_nxt[j] = hs * ws;
      end else begin
        prod_nxt[j] = '0;
      end
    end
  end

  always_comb begin
    acc_nxt = '0;
    for (int j = 0; j < MAX_TAPS; j++) begin
      acc_nxt = acc_nxt + ACC_W'(prod_r[j]);
    end
  end

  // round half up by bias and floor shift, then clip to the sample range
  assign rnd = acc_r + ACC_BIAS;
  assign q   = rnd >>> FRAC_SHIFT;

  always_comb begin
    rsp_nxt.out_channel = req_r.channel_index;
    rsp_nxt.out_batch   = req_r.batch_slot;
    if (q > ACC_HI) begin
      rsp_nxt.filtered_value = SAMPLE_BITS'(SAT_HI);
      rsp_nxt.saturated      = 1'b1;
    end else if (q < ACC_LO) begin
      rsp_nxt.filtered_value = SAMPLE_BITS'(SAT_LO);
      rsp_nxt.saturated      = 1'b1;
    end else begin
      rsp_nxt.filtered_value = q[SAMPLE_BITS-1:0];
      rsp_nxt.saturated      = 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // sequencer, config register and output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      clr_cnt_r     <= '0;
      kernel_taps_r <= KTAPS_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        kernel_taps_r <= cfg_wr_data;
      end

      // the output stage reloads the register itself on a transfer
      if (out_xfer && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            req_r <= in_req;
            if (keep) begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          prod_r <= prod_nxt;
          if (req_r.req_type == REQ_SAMPLE) begin
            state_r <= S_SUM;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_SUM: begin
          acc_r   <= acc_nxt;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // wait here while an older result is still held up downstream
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_rsp_r   <= rsp_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------

  // history and weight write-backs belong to different request kinds
  assert property (@(posedge clk) disable iff (!rst_n) !(hist_we && wt_we))
    else $error("history and weight memories written in the same cycle");

  // a new result only ever comes out of the output stage
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("output valid rose outside the output stage");

  // coming out of reset the clearing sweep blocks input
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("input accepted before the history clear");

endmodule
